// ===== sv/psu_pkg.sv =====
// psu_pkg: shared types, register indexes and lookup functions of the pulse sound unit
// no dependencies
`default_nettype none
package psu_pkg;

  // transaction function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // register file indexes relative to 0xFF10
  localparam logic [5:0] IDX_SWEEP   = 6'h00;
  localparam logic [5:0] IDX_LEN1    = 6'h01;
  localparam logic [5:0] IDX_ENV1    = 6'h02;
  localparam logic [5:0] IDX_FLO1    = 6'h03;
  localparam logic [5:0] IDX_FHI1    = 6'h04;
  localparam logic [5:0] IDX_LEN2    = 6'h06;
  localparam logic [5:0] IDX_ENV2    = 6'h07;
  localparam logic [5:0] IDX_FHI2    = 6'h09;
  localparam logic [5:0] IDX_POWER   = 6'h16;
  localparam logic [5:0] IDX_WAVE    = 6'h20;

  localparam int NUM_CTRL   = 22;
  localparam int NUM_WAVE   = 16;
  localparam int CHAN2_BASE = 5;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [15:0] div_count;
  } psu_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
    logic [1:0] chan_status;
  } psu_result_t;

  // read-back OR mask of the control registers
  function automatic logic [7:0] read_mask(input logic [5:0] idx);
    logic [7:0] m;
    unique case (idx)
      6'h00: m = 8'h80;
      6'h01: m = 8'h3F;
      6'h02: m = 8'h00;
      6'h03: m = 8'hFF;
      6'h04: m = 8'hBF;
      6'h05: m = 8'hFF;
      6'h06: m = 8'h3F;
      6'h07: m = 8'h00;
      6'h08: m = 8'hFF;
      6'h09: m = 8'hBF;
      6'h0A: m = 8'h7F;
      6'h0B: m = 8'hFF;
      6'h0C: m = 8'h9F;
      6'h0D: m = 8'hFF;
      6'h0E: m = 8'hBF;
      6'h0F: m = 8'hFF;
      6'h10: m = 8'hFF;
      6'h11: m = 8'h00;
      6'h12: m = 8'h00;
      6'h13: m = 8'hBF;
      6'h14: m = 8'h00;
      6'h15: m = 8'h00;
      6'h16: m = 8'h70;
      6'h17, 6'h18, 6'h19, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h1F: m = 8'hFF;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // duty waveform, one bit per step
  function automatic logic [7:0] duty_wave(input logic [1:0] sel);
    logic [7:0] p;
    unique case (sel)
      2'd0: p = 8'h01;
      2'd1: p = 8'h81;
      2'd2: p = 8'h87;
      default: p = 8'h7E;
    endcase
    return p;
  endfunction

  // sweep frequency step; bit 11 set means overflow
  function automatic logic [11:0] sweep_calc(input logic [10:0] f, input logic [7:0] nr10);
    logic [10:0] d;
    d = f >> nr10[2:0];
    return nr10[3] ? ({1'b0, f} - {1'b0, d}) : ({1'b0, f} + {1'b0, d});
  endfunction

  // period reload (2048 - f) * 4
  function automatic logic [13:0] period_reload(input logic [10:0] f);
    logic [11:0] t;
    t = 12'd2048 - {1'b0, f};
    return {t, 2'b00};
  endfunction

endpackage
`default_nettype wire

// ===== sv/psu_if.sv =====
// psu_in_if / psu_out_if: valid-ready channels of the pulse sound unit
// no dependencies
`default_nettype none
interface psu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [15:0] div_count;
  modport source (output valid, func, addr, wdata, div_count, input ready);
  modport sink (input valid, func, addr, wdata, div_count, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic [3:0] pulse1_level;
  logic [3:0] pulse2_level;
  logic [1:0] chan_status;
  modport source (output valid, rdata, pulse1_level, pulse2_level, chan_status, input ready);
  modport sink (input valid, rdata, pulse1_level, pulse2_level, chan_status, output ready);
endinterface
`default_nettype wire

// ===== sv/psu_core.sv =====
// psu_core: register file, frame sequencer and both pulse channels
// depends on psu_pkg; state advances by one transaction when en is high
`default_nettype none
module psu_core #(
  parameter int DIV_TAP_BIT = 12
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  psu_pkg::psu_item_t  item,
  output psu_pkg::psu_result_t result
);

  logic [7:0]  regs [psu_pkg::NUM_CTRL];
  logic [7:0]  wave [psu_pkg::NUM_WAVE];
  logic        apu_on;
  logic [2:0]  seq_step;
  logic [1:0]  chan_on;
  logic [1:0]  dac_on;
  logic [6:0]  len [2];
  logic [13:0] ptimer [2];
  logic [3:0]  vol [2];
  logic [2:0]  etimer [2];
  logic [2:0]  duty [2];
  logic [3:0]  sweep_cnt;
  logic        sweep_armed;
  logic [10:0] sweep_freq;

  logic [7:0]  regs_next [psu_pkg::NUM_CTRL];
  logic [7:0]  wave_next [psu_pkg::NUM_WAVE];
  logic        apu_on_next;
  logic [2:0]  seq_step_next;
  logic [1:0]  chan_on_next;
  logic [1:0]  dac_on_next;
  logic [6:0]  len_next [2];
  logic [13:0] ptimer_next [2];
  logic [3:0]  vol_next [2];
  logic [2:0]  etimer_next [2];
  logic [2:0]  duty_next [2];
  logic [3:0]  sweep_cnt_next;
  logic        sweep_armed_next;
  logic [10:0] sweep_freq_next;
  logic [7:0]  rdata;

  // next state for one transaction
  always_comb begin
    logic [15:0] div_p1;
    logic        fall;
    logic        in_win;
    logic [5:0]  idx;
    logic [7:0]  v;
    logic [7:0]  nr10;
    logic [7:0]  nr2;
    logic [2:0]  per;
    logic [11:0] nf;
    logic [10:0] f;
    logic        do_len;
    logic        do_sweep;
    logic        do_env;
    logic        trig;
    int          b;
    regs_next        = regs;
    wave_next        = wave;
    apu_on_next      = apu_on;
    seq_step_next    = seq_step;
    chan_on_next     = chan_on;
    dac_on_next      = dac_on;
    len_next         = len;
    ptimer_next      = ptimer;
    vol_next         = vol;
    etimer_next      = etimer;
    duty_next        = duty;
    sweep_cnt_next   = sweep_cnt;
    sweep_armed_next = sweep_armed;
    sweep_freq_next  = sweep_freq;
    rdata            = 8'h00;
    div_p1   = item.div_count + 16'd1;
    fall     = item.div_count[DIV_TAP_BIT] & ~div_p1[DIV_TAP_BIT];
    in_win   = (item.addr[15:8] == 8'hFF) && (item.addr[7:4] != 4'h0)
               && (item.addr[7:6] == 2'b00);
    idx      = 6'(item.addr[7:0] - 8'h10);
    v        = item.wdata;
    nr10     = regs[0];
    do_len   = 1'b0;
    do_sweep = 1'b0;
    do_env   = 1'b0;
    trig     = 1'b0;
    nf       = '0;
    f        = '0;
    nr2      = '0;
    per      = '0;
    b        = 0;

    unique case (item.func)
      psu_pkg::FUNC_TICK: begin
        // frame sequencer step
        if (fall) begin
          unique case (seq_step)
            3'd0, 3'd4: do_len = 1'b1;
            3'd2, 3'd6: begin
              do_len   = 1'b1;
              do_sweep = 1'b1;
            end
            3'd7: do_env = 1'b1;
            default: ;
          endcase
          seq_step_next = seq_step + 3'd1;
        end
        // length counters
        if (do_len) begin
          for (int c = 0; c < 2; c++) begin
            b = c * psu_pkg::CHAN2_BASE;
            if (chan_on[c] && regs[b + 4][6] && len[c] != 7'd0) begin
              len_next[c] = len[c] - 7'd1;
              if (len[c] == 7'd1) chan_on_next[c] = 1'b0;
            end
          end
        end
        // frequency sweep, channel one
        if (do_sweep) begin
          per = nr10[6:4];
          if (sweep_cnt != 4'd0) sweep_cnt_next = sweep_cnt - 4'd1;
          if (sweep_cnt_next == 4'd0) begin
            sweep_cnt_next = (per != 3'd0) ? {1'b0, per} : 4'd8;
            if (sweep_armed && per != 3'd0) begin
              nf = psu_pkg::sweep_calc(sweep_freq, nr10);
              if (nf[11]) begin
                chan_on_next[0] = 1'b0;
              end else if (nr10[2:0] != 3'd0) begin
                sweep_freq_next = nf[10:0];
                regs_next[3]    = nf[7:0];
                regs_next[4]    = {regs[4][7:3], nf[10:8]};
                if (psu_pkg::sweep_calc(nf[10:0], nr10) > 12'd2047) chan_on_next[0] = 1'b0;
              end
            end
          end
        end
        // volume envelopes
        if (do_env) begin
          for (int c = 0; c < 2; c++) begin
            b   = c * psu_pkg::CHAN2_BASE;
            nr2 = regs[b + 2];
            if (nr2[2:0] != 3'd0) begin
              if (etimer[c] != 3'd0) etimer_next[c] = etimer[c] - 3'd1;
              if (etimer_next[c] == 3'd0) begin
                etimer_next[c] = nr2[2:0];
                if (nr2[3]) begin
                  if (vol[c] != 4'd15) vol_next[c] = vol[c] + 4'd1;
                end else if (vol[c] != 4'd0) begin
                  vol_next[c] = vol[c] - 4'd1;
                end
              end
            end
          end
        end
        // period timers and duty position
        for (int c = 0; c < 2; c++) begin
          b = c * psu_pkg::CHAN2_BASE;
          if (chan_on_next[c]) begin
            if (ptimer[c] != 14'd0) ptimer_next[c] = ptimer[c] - 14'd1;
            if (ptimer_next[c] == 14'd0) begin
              f = {regs_next[b + 4][2:0], regs_next[b + 3]};
              ptimer_next[c] = psu_pkg::period_reload(f);
              duty_next[c]   = duty[c] + 3'd1;
            end
          end
        end
      end
      psu_pkg::FUNC_READ: begin
        // bus read with mask
        if (!in_win) begin
          rdata = 8'hFF;
        end else if (idx == psu_pkg::IDX_POWER) begin
          rdata = {apu_on, 3'b111, 2'b00, chan_on[1], chan_on[0]};
        end else if (idx >= psu_pkg::IDX_WAVE) begin
          rdata = wave[idx[3:0]];
        end else if (!apu_on) begin
          rdata = psu_pkg::read_mask(idx);
        end else if (idx < psu_pkg::IDX_POWER) begin
          rdata = regs[idx[4:0]] | psu_pkg::read_mask(idx);
        end else begin
          rdata = psu_pkg::read_mask(idx);
        end
      end
      psu_pkg::FUNC_WRITE: begin
        if (in_win) begin
          if (idx == psu_pkg::IDX_POWER) begin
            // power register; turning off clears the control registers
            apu_on_next = v[7];
            if (apu_on && !v[7]) begin
              for (int k = 0; k < psu_pkg::NUM_CTRL; k++) regs_next[k] = 8'h00;
              chan_on_next = 2'b00;
            end
          end else if (idx >= psu_pkg::IDX_WAVE) begin
            wave_next[idx[3:0]] = v;
          end else if (apu_on && idx < psu_pkg::IDX_POWER) begin
            regs_next[idx[4:0]] = v;
            unique case (idx)
              psu_pkg::IDX_ENV1: begin
                dac_on_next[0] = v[7:3] != 5'd0;
                if (v[7:3] == 5'd0) chan_on_next[0] = 1'b0;
              end
              psu_pkg::IDX_ENV2: begin
                dac_on_next[1] = v[7:3] != 5'd0;
                if (v[7:3] == 5'd0) chan_on_next[1] = 1'b0;
              end
              psu_pkg::IDX_LEN1: len_next[0] = 7'd64 - {1'b0, v[5:0]};
              psu_pkg::IDX_LEN2: len_next[1] = 7'd64 - {1'b0, v[5:0]};
              psu_pkg::IDX_FHI1, psu_pkg::IDX_FHI2: trig = v[7];
              default: ;
            endcase
            // channel trigger
            if (trig) begin
              for (int c = 0; c < 2; c++) begin
                b = c * psu_pkg::CHAN2_BASE;
                if ((c == 0) == (idx == psu_pkg::IDX_FHI1)) begin
                  nr2 = regs_next[b + 2];
                  dac_on_next[c] = nr2[7:3] != 5'd0;
                  if (nr2[7:3] == 5'd0) begin
                    chan_on_next[c] = 1'b0;
                  end else begin
                    chan_on_next[c] = 1'b1;
                    if (len[c] == 7'd0) len_next[c] = 7'd64;
                    f = {regs_next[b + 4][2:0], regs_next[b + 3]};
                    ptimer_next[c] = psu_pkg::period_reload(f);
                    vol_next[c]    = nr2[7:4];
                    etimer_next[c] = nr2[2:0];
                    if (c == 0) begin
                      per = nr10[6:4];
                      sweep_freq_next  = f;
                      sweep_cnt_next   = (per != 3'd0) ? {1'b0, per} : 4'd8;
                      sweep_armed_next = (per != 3'd0) || (nr10[2:0] != 3'd0);
                      if (nr10[2:0] != 3'd0 && psu_pkg::sweep_calc(f, nr10) > 12'd2047)
                        chan_on_next[0] = 1'b0;
                    end
                  end
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // channel levels after this transaction
  always_comb begin
    logic [7:0] p1;
    logic [7:0] p2;
    p1 = psu_pkg::duty_wave(regs_next[1][7:6]);
    p2 = psu_pkg::duty_wave(regs_next[psu_pkg::CHAN2_BASE + 1][7:6]);
    result.rdata        = rdata;
    result.pulse1_level = (chan_on_next[0] && dac_on_next[0] && p1[duty_next[0]])
                          ? vol_next[0] : 4'd0;
    result.pulse2_level = (chan_on_next[1] && dac_on_next[1] && p2[duty_next[1]])
                          ? vol_next[1] : 4'd0;
    result.chan_status  = chan_on_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < psu_pkg::NUM_CTRL; k++) regs[k] <= 8'h00;
      for (int k = 0; k < psu_pkg::NUM_WAVE; k++) wave[k] <= 8'h00;
      apu_on      <= 1'b1;
      seq_step    <= 3'd0;
      chan_on     <= 2'b00;
      dac_on      <= 2'b00;
      for (int c = 0; c < 2; c++) begin
        len[c]    <= '0;
        ptimer[c] <= '0;
        vol[c]    <= '0;
        etimer[c] <= '0;
        duty[c]   <= '0;
      end
      sweep_cnt   <= '0;
      sweep_armed <= 1'b0;
      sweep_freq  <= '0;
    end else if (en) begin
      regs        <= regs_next;
      wave        <= wave_next;
      apu_on      <= apu_on_next;
      seq_step    <= seq_step_next;
      chan_on     <= chan_on_next;
      dac_on      <= dac_on_next;
      len         <= len_next;
      ptimer      <= ptimer_next;
      vol         <= vol_next;
      etimer      <= etimer_next;
      duty        <= duty_next;
      sweep_cnt   <= sweep_cnt_next;
      sweep_armed <= sweep_armed_next;
      sweep_freq  <= sweep_freq_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pulse_sound_unit_with_sweep.sv =====
// pulse_sound_unit_with_sweep: two square-wave channels with sweep and frame sequencer
// depends on psu_pkg, psu_in_if, psu_out_if and psu_core
//
// Usage:
//   in_ch carries one transaction per item: a clock tick, a bus read or a bus
//   write (func, addr, wdata, div_count). out_ch returns exactly one result
//   per item: read data (zero unless a read), both 4-bit channel levels and
//   the channel-on bits, as they stand after that item.
//   The item is captured in an input register; the whole update then runs
//   in psu_core and lands in the result register.
//   Throughput is one item per cycle while the receiver takes each result;
//   psu_core updates its whole state for each item.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ch.ready then drops until the result is taken.
//   Reset (rst, synchronous) empties both registers and returns the unit
//   to power on with all registers zero and both channels off.
`default_nettype none
module pulse_sound_unit_with_sweep #(
  parameter int DIV_TAP_BIT = 12
) (
  input wire         clk,
  input wire         rst,
  psu_in_if.sink     in_ch,
  psu_out_if.source  out_ch
);

  logic                 s_valid;
  psu_pkg::psu_item_t   s_item;
  logic                 o_valid;
  psu_pkg::psu_result_t o_result;
  psu_pkg::psu_result_t core_result;
  logic                 out_free;
  logic                 advance;

  assign out_free    = !o_valid || out_ch.ready;
  assign advance     = s_valid && out_free;
  assign in_ch.ready = !s_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s_item <= '{func: in_ch.func, addr: in_ch.addr, wdata: in_ch.wdata,
                  div_count: in_ch.div_count};
    end
  end

  psu_core #(
    .DIV_TAP_BIT(DIV_TAP_BIT)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .item  (s_item),
    .result(core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_result <= core_result;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.rdata        = o_result.rdata;
  assign out_ch.pulse1_level = o_result.pulse1_level;
  assign out_ch.pulse2_level = o_result.pulse2_level;
  assign out_ch.chan_status  = o_result.chan_status;

`ifndef ASSERT_OFF
  // a staged item moves into the result register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> o_valid)
    else $error("staged transaction not moved to result register");

  // a blocked staged item stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !out_free) |=> (s_valid && $stable(s_item)))
    else $error("staged transaction lost while blocked");

  // a stalled result is not overwritten
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !out_ch.ready) |=> (o_valid && $stable(o_result)))
    else $error("stalled result changed");

  // reads outside a read transaction return zero
  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && s_item.func != psu_pkg::FUNC_READ) |=> (o_result.rdata == 8'h00))
    else $error("nonzero read data on non-read transaction");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of pulse_sound_unit_with_sweep
// depends on psu_pkg, psu_if.sv (psu_in_if, psu_out_if) and the unit's RTL
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  logic clk;
  logic rst;
  int   cycle_cnt;
  int   err_cnt;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  logic [15:0] div_val;

  psu_in_if  in_ch ();
  psu_out_if out_ch ();

  pulse_sound_unit_with_sweep DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock, period 8 ns
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // predictor state of the sound unit
  // ---------------------------------------------------------------
  logic [7:0]  m_regs [48];
  logic        m_power;
  logic [2:0]  m_step;
  logic        m_on   [2];
  logic        m_dac  [2];
  logic [6:0]  m_len  [2];
  logic [13:0] m_ptmr [2];
  logic [3:0]  m_vol  [2];
  logic [2:0]  m_etmr [2];
  logic [2:0]  m_duty [2];
  logic [3:0]  m_swtmr;
  logic        m_swarm;
  logic [10:0] m_swfreq;
  psu_pkg::psu_result_t expected_q [$];

  function automatic logic [7:0] mask_of(input int i);
    case (i)
      0: return 8'h80;  1: return 8'h3F;  2: return 8'h00;  3: return 8'hFF;
      4: return 8'hBF;  5: return 8'hFF;  6: return 8'h3F;  7: return 8'h00;
      8: return 8'hFF;  9: return 8'hBF;  10: return 8'h7F; 11: return 8'hFF;
      12: return 8'h9F; 13: return 8'hFF; 14: return 8'hBF; 15: return 8'hFF;
      16: return 8'hFF; 17: return 8'h00; 18: return 8'h00; 19: return 8'hBF;
      20: return 8'h00; 21: return 8'h00; 22: return 8'h70;
      default: return (i < 32) ? 8'hFF : 8'h00;
    endcase
  endfunction

  function automatic int chan_base(input int c);
    return c == 0 ? 0 : psu_pkg::CHAN2_BASE;
  endfunction

  function automatic int chan_freq(input int c);
    return int'({m_regs[chan_base(c) + 4][2:0], m_regs[chan_base(c) + 3]});
  endfunction

  function automatic int next_sweep(input int f, input logic [7:0] nr10);
    int d;
    d = f >> nr10[2:0];
    return nr10[3] ? f - d : f + d;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < 48; i++) m_regs[i] = 8'h00;
    m_regs[psu_pkg::IDX_POWER] = 8'hF1;
    m_power = 1'b1;
    m_step = 3'd0;
    for (int c = 0; c < 2; c++) begin
      m_on[c] = 1'b0; m_dac[c] = 1'b0; m_len[c] = '0; m_ptmr[c] = '0;
      m_vol[c] = '0; m_etmr[c] = '0; m_duty[c] = '0;
    end
    m_swtmr = '0; m_swarm = 1'b0; m_swfreq = '0;
    expected_q.delete();
  endtask

  task automatic step_length();
    for (int c = 0; c < 2; c++) begin
      if (m_on[c] && m_regs[chan_base(c) + 4][6] && m_len[c] > 0) begin
        m_len[c] = m_len[c] - 7'd1;
        if (m_len[c] == 0) m_on[c] = 1'b0;
      end
    end
  endtask

  task automatic step_sweep();
    logic [7:0] nr10;
    int per;
    int nf;
    nr10 = m_regs[psu_pkg::IDX_SWEEP];
    per = int'(nr10[6:4]);
    if (m_swtmr > 0) m_swtmr = m_swtmr - 4'd1;
    if (m_swtmr != 0) return;
    m_swtmr = per != 0 ? 4'(per) : 4'd8;
    if (!m_swarm || per == 0) return;
    nf = next_sweep(int'(m_swfreq), nr10);
    if (nf > 2047) begin
      m_on[0] = 1'b0;
      return;
    end
    if (nr10[2:0] != 0) begin
      m_swfreq = 11'(nf);
      m_regs[psu_pkg::IDX_FLO1] = nf[7:0];
      m_regs[psu_pkg::IDX_FHI1] = {m_regs[psu_pkg::IDX_FHI1][7:3], nf[10:8]};
      if (next_sweep(nf, nr10) > 2047) m_on[0] = 1'b0;
    end
  endtask

  task automatic clock_envelope();
    logic [7:0] nr2;
    for (int c = 0; c < 2; c++) begin
      nr2 = m_regs[chan_base(c) + 2];
      if (nr2[2:0] != 0) begin
        if (m_etmr[c] > 0) m_etmr[c] = m_etmr[c] - 3'd1;
        if (m_etmr[c] == 0) begin
          m_etmr[c] = nr2[2:0];
          if (nr2[3]) begin
            if (m_vol[c] < 15) m_vol[c] = m_vol[c] + 4'd1;
          end else if (m_vol[c] > 0) begin
            m_vol[c] = m_vol[c] - 4'd1;
          end
        end
      end
    end
  endtask

  task automatic trigger_chan(input int c);
    logic [7:0] nr2;
    logic [7:0] nr10;
    int f;
    nr2 = m_regs[chan_base(c) + 2];
    m_dac[c] = nr2[7:3] != 0;
    if (!m_dac[c]) begin
      m_on[c] = 1'b0;
      return;
    end
    m_on[c] = 1'b1;
    if (m_len[c] == 0) m_len[c] = 7'd64;
    f = chan_freq(c);
    m_ptmr[c] = 14'((2048 - f) * 4);
    m_vol[c] = nr2[7:4];
    m_etmr[c] = nr2[2:0];
    if (c == 0) begin
      nr10 = m_regs[psu_pkg::IDX_SWEEP];
      m_swfreq = 11'(f);
      m_swtmr = nr10[6:4] != 0 ? {1'b0, nr10[6:4]} : 4'd8;
      m_swarm = nr10[6:4] != 0 || nr10[2:0] != 0;
      if (nr10[2:0] != 0 && next_sweep(f, nr10) > 2047) m_on[0] = 1'b0;
    end
  endtask

  function automatic logic [7:0] bus_read(input logic [15:0] a);
    int i;
    if (a < 16'hFF10 || a > 16'hFF3F) return 8'hFF;
    i = int'(a - 16'hFF10);
    if (i == psu_pkg::IDX_POWER) return {m_power, 3'b111, 2'b00, m_on[1], m_on[0]};
    if (i >= psu_pkg::IDX_WAVE) return m_regs[i];
    if (!m_power) return mask_of(i);
    return m_regs[i] | mask_of(i);
  endfunction

  task automatic bus_write(input logic [15:0] a, input logic [7:0] v);
    int i;
    logic was;
    if (a < 16'hFF10 || a > 16'hFF3F) return;
    i = int'(a - 16'hFF10);
    if (i == psu_pkg::IDX_POWER) begin
      was = m_power;
      m_power = v[7];
      if (was && !m_power) begin
        for (int k = 0; k < psu_pkg::IDX_POWER; k++) m_regs[k] = 8'h00;
        m_on[0] = 1'b0;
        m_on[1] = 1'b0;
      end
      m_regs[psu_pkg::IDX_POWER] = {v[7], 7'd0};
      return;
    end
    if (i >= psu_pkg::IDX_WAVE) begin
      m_regs[i] = v;
      return;
    end
    if (!m_power) return;
    m_regs[i] = v;
    case (i)
      psu_pkg::IDX_ENV1, psu_pkg::IDX_ENV2: begin
        m_dac[i == psu_pkg::IDX_ENV1 ? 0 : 1] = v[7:3] != 0;
        if (v[7:3] == 0) m_on[i == psu_pkg::IDX_ENV1 ? 0 : 1] = 1'b0;
      end
      psu_pkg::IDX_LEN1: m_len[0] = 7'd64 - {1'b0, v[5:0]};
      psu_pkg::IDX_LEN2: m_len[1] = 7'd64 - {1'b0, v[5:0]};
      psu_pkg::IDX_FHI1: if (v[7]) trigger_chan(0);
      psu_pkg::IDX_FHI2: if (v[7]) trigger_chan(1);
      default: ;
    endcase
  endtask

  task automatic clock_tick(input logic [15:0] dv);
    logic [15:0] nx;
    nx = dv + 16'd1;
    if (dv[12] && !nx[12]) begin
      case (m_step)
        3'd0, 3'd4: step_length();
        3'd2, 3'd6: begin
          step_length();
          step_sweep();
        end
        3'd7: clock_envelope();
        default: ;
      endcase
      m_step = m_step + 3'd1;
    end
    for (int c = 0; c < 2; c++) begin
      if (m_on[c]) begin
        if (m_ptmr[c] > 0) m_ptmr[c] = m_ptmr[c] - 14'd1;
        if (m_ptmr[c] == 0) begin
          m_ptmr[c] = 14'((2048 - chan_freq(c)) * 4);
          m_duty[c] = m_duty[c] + 3'd1;
        end
      end
    end
  endtask

  function automatic logic [3:0] chan_level(input int c);
    logic [7:0] pat;
    case (m_regs[chan_base(c) + 1][7:6])
      2'd0: pat = 8'h01;
      2'd1: pat = 8'h81;
      2'd2: pat = 8'h87;
      default: pat = 8'h7E;
    endcase
    if (!m_on[c] || !m_dac[c]) return 4'd0;
    return pat[m_duty[c]] ? m_vol[c] : 4'd0;
  endfunction

  // advance the predictor by one transaction and queue the expected result
  task automatic predict_sound(input psu_pkg::psu_item_t it);
    psu_pkg::psu_result_t r;
    r = '0;
    case (it.func)
      psu_pkg::FUNC_TICK:  clock_tick(it.div_count);
      psu_pkg::FUNC_READ:  r.rdata = bus_read(it.addr);
      psu_pkg::FUNC_WRITE: bus_write(it.addr, it.wdata);
      default: ;
    endcase
    r.pulse1_level = chan_level(0);
    r.pulse2_level = chan_level(1);
    r.chan_status = {m_on[1], m_on[0]};
    expected_q.push_back(r);
  endtask

  // ---------------------------------------------------------------
  // driver: one transaction per call, changes on the falling edge
  // ---------------------------------------------------------------
  task automatic send_item(input logic [1:0] f, input logic [15:0] a,
                           input logic [7:0] d, input logic [15:0] dv);
    psu_pkg::psu_item_t it;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    it = '{func: f, addr: a, wdata: d, div_count: dv};
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.addr      <= a;
    in_ch.wdata     <= d;
    in_ch.div_count <= dv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_sound(it);
    @(negedge clk);
  endtask

  task automatic tick_item();
    send_item(psu_pkg::FUNC_TICK, 16'h0000, 8'h00, div_val);
    div_val = div_val + 16'd1;
  endtask

  task automatic write_reg(input logic [5:0] idx, input logic [7:0] v);
    send_item(psu_pkg::FUNC_WRITE, 16'hFF10 + {10'h000, idx}, v, div_val);
  endtask

  task automatic read_reg(input logic [5:0] idx);
    send_item(psu_pkg::FUNC_READ, 16'hFF10 + {10'h000, idx}, 8'h00, div_val);
  endtask

  // receiver ready, random stalls
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    psu_pkg::psu_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result rdata=%h", $realtime, out_ch.rdata);
        err_cnt = err_cnt + 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.rdata !== out_ch.rdata || exp_r.pulse1_level !== out_ch.pulse1_level ||
            exp_r.pulse2_level !== out_ch.pulse2_level ||
            exp_r.chan_status !== out_ch.chan_status) begin
          $display("%0t: mismatch expected %h/%h/%h/%h actual %h/%h/%h/%h", $realtime,
                   exp_r.rdata, exp_r.pulse1_level, exp_r.pulse2_level, exp_r.chan_status,
                   out_ch.rdata, out_ch.pulse1_level, out_ch.pulse2_level,
                   out_ch.chan_status);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  task automatic test_bus_map();
    send_item(psu_pkg::FUNC_READ, 16'h0000, 8'h00, 16'h0000);
    send_item(psu_pkg::FUNC_READ, 16'hFFFF, 8'h00, 16'hFFFF);
    send_item(psu_pkg::FUNC_WRITE, 16'hFF0F, 8'hFF, 16'h0000);
    send_item(psu_pkg::FUNC_UNUSED, 16'hFF12, 8'hFF, 16'h1FFF);
    write_reg(psu_pkg::IDX_WAVE, 8'hA5);
    read_reg(psu_pkg::IDX_WAVE);
    read_reg(6'h2F);
    read_reg(psu_pkg::IDX_POWER);
    write_reg(psu_pkg::IDX_POWER, 8'h00);
    read_reg(psu_pkg::IDX_SWEEP);
    write_reg(psu_pkg::IDX_ENV1, 8'hF0);
    read_reg(psu_pkg::IDX_ENV1);
    tick_item();
    write_reg(psu_pkg::IDX_POWER, 8'hFF);
    read_reg(psu_pkg::IDX_POWER);
  endtask

  task automatic test_channels();
    write_reg(psu_pkg::IDX_SWEEP, 8'h11);
    write_reg(psu_pkg::IDX_LEN1, 8'hBF);
    write_reg(psu_pkg::IDX_ENV1, 8'hF1);
    write_reg(psu_pkg::IDX_FLO1, 8'hFF);
    write_reg(psu_pkg::IDX_FHI1, 8'hC7);
    write_reg(psu_pkg::IDX_LEN2, 8'h40);
    write_reg(psu_pkg::IDX_ENV2, 8'h00);
    write_reg(psu_pkg::IDX_FHI2, 8'h80);
    write_reg(psu_pkg::IDX_ENV2, 8'h0F);
    write_reg(psu_pkg::IDX_FHI2, 8'hC7);
    div_val = 16'h1FF0;
    repeat (40) tick_item();
  endtask

  // mostly well-formed channel setups with long tick runs
  task automatic test_random(input int n);
    int k;
    int sel;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        write_reg(6'($urandom_range(0, 5) + ($urandom_range(1) ? psu_pkg::CHAN2_BASE : 0)),
                  8'($urandom));
        k++;
      end else if (sel < 16) begin
        write_reg(6'(psu_pkg::IDX_FHI1 + ($urandom_range(1) ? psu_pkg::CHAN2_BASE : 0)),
                  8'($urandom) | 8'h80);
        k++;
      end else if (sel < 20) begin
        read_reg(6'($urandom_range(0, 47)));
        k++;
      end else if (sel < 22) begin
        write_reg(psu_pkg::IDX_POWER,
                  $urandom_range(3) == 0 ? 8'h00 : 8'h80 | 8'($urandom));
        k++;
      end else if (sel < 24) begin
        send_item(2'($urandom_range(3)), 16'($urandom), 8'($urandom), 16'($urandom));
        k++;
      end else if (sel < 26) begin
        write_reg(6'($urandom_range(0, 47)), 8'($urandom));
        k++;
      end else begin
        // at times jump near a divider edge, then run ticks
        if ($urandom_range(3) == 0) div_val = 16'(16'h1FF8 | ($urandom_range(7) << 13));
        repeat ($urandom_range(1, 12)) begin
          tick_item();
          k++;
        end
      end
    end
  endtask

  task automatic drain();
    int w;
    w = 0;
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (10) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cycle_cnt = 0;
    err_cnt = 0;
    div_val = 16'h0000;
    snd_idle_pct = 10;
    rcv_idle_pct = 83;
    in_ch.valid = 1'b0;
    in_ch.func = psu_pkg::FUNC_TICK;
    in_ch.addr = 16'h0000;
    in_ch.wdata = 8'h00;
    in_ch.div_count = 16'h0000;
    out_ch.ready = 1'b0;
    model_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_bus_map();
    test_channels();
    test_random(620);
    snd_idle_pct = 83;
    rcv_idle_pct = 10;
    test_random(620);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(640);
    drain();
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/psu_pkg.sv
sv/psu_if.sv
sv/psu_core.sv
sv/pulse_sound_unit_with_sweep.sv
verif/tb_top.sv
